### design/dq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// No dependencies.
package dq_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } dq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec_op;
    logic read_slots;
    logic load_out;
  } dq_ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;
  } dq_dp_stat_t;

endpackage

### design/double_ended_queue_top.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: controller plus datapath.
// Depends on dq_pkg, dq_ctrl and dq_dp.
//
// Bounded double-ended queue of DEPTH signed 32-bit words in a circular buffer.
// Each input transfer carries one command (push front/back, pop front/back) and
// yields exactly one result transfer with status, front and back words, count
// and an empty flag. After the accepting edge come index/count update with slot
// write, registered slot read and result load, in that order. A new command is
// accepted only after the previous result has been loaded. The next command is
// accepted while a result waits in the output register; if that result still
// waits when the next one is ready, the input stalls. Pop on empty and push on
// full report an error and leave the queue unchanged. No clearing pass is
// needed after reset.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int OUT_W = ((2 * VALUE_W + CNT_W + 1 + 7) / 8) * 8
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // value
  input  logic [1:0]         in_tuser,   // command
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // front_value, back_value, occupancy, is_empty
  output logic [1:0]         out_tuser   // status
);

  dq_ctrl_cmd_t       cmd;
  dq_dp_stat_t        stat;
  logic [VALUE_W-1:0] out_front, out_back;
  logic [CNT_W-1:0]   out_count;
  logic               out_empty;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dq_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .item_cmd   (in_tuser),
    .item_value (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_front  (out_front),
    .out_back   (out_back),
    .out_count  (out_count),
    .out_empty  (out_empty)
  );

  assign out_tdata = OUT_W'({out_empty, out_count, out_back, out_front});

endmodule

### design/dq_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller for the double-ended queue.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         out_tready,
  input  dq_dp_stat_t  stat,
  output dq_ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_tvalid && in_ready_r;
  assign out_free = !stat.out_full || out_tready;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_EXEC;
          in_ready_nxt = 1'b0;
        end
      end
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_tready      = in_ready_r;
  assign cmd.load_item  = accept;
  assign cmd.exec_op    = (state_r == S_EXEC);
  assign cmd.read_slots = (state_r == S_READ);
  assign cmd.load_out   = (state_r == S_DONE) && out_free;

endmodule

### design/dq_dp.sv
`timescale 1ns / 1ps
// Datapath for the double-ended queue: slot memory, indices, count, result register.
// Depends on dq_pkg.
module dq_dp
  import dq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
)(
  input  logic               clk,
  input  logic               rst_n,
  input  dq_ctrl_cmd_t       cmd,
  output dq_dp_stat_t        stat,
  input  logic [1:0]         item_cmd,
  input  logic [VALUE_W-1:0] item_value,
  input  logic               out_tready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [VALUE_W-1:0] out_front,
  output logic [VALUE_W-1:0] out_back,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_empty
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  logic [VALUE_W-1:0] mem [DEPTH];

  dq_cmd_t            op_r;
  logic [VALUE_W-1:0] value_r;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [IDX_W-1:0]   back_r, back_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  dq_status_t         status_r, status_nxt;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] rd_front_r, rd_back_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [VALUE_W-1:0] out_front_r, out_back_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_empty_r;
  logic               is_full, is_empty;

  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    case (op_r)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = idx_dec(front_r);
          wr_en     = 1'b1;
          wr_addr   = idx_dec(front_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          back_nxt  = idx_inc(back_r);
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          front_nxt = idx_inc(front_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          back_nxt  = idx_dec(back_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= dq_cmd_t'(item_cmd);
      value_r <= item_value;
    end
    if (cmd.exec_op) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec_op) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec_op && wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (cmd.read_slots) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[idx_dec(back_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_front_r  <= is_empty ? '0 : rd_front_r;
      out_back_r   <= is_empty ? '0 : rd_back_r;
      out_count_r  <= count_r;
      out_empty_r  <= is_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_full = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_front     = out_front_r;
  assign out_back      = out_back_r;
  assign out_count     = out_count_r;
  assign out_empty     = out_empty_r;

endmodule

### design/dq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue_top.
module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int OUT_W = ((2 * VALUE_W + CNT_W + 1 + 7) / 8) * 8
)(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser
);

  localparam int CNT_LSB = 2 * VALUE_W;
  localparam int EMP_BIT = CNT_LSB + CNT_W;

  logic [CNT_W-1:0]   occ;
  logic               emp;
  logic [VALUE_W-1:0] fv, bv;

  assign fv  = out_tdata[VALUE_W-1:0];
  assign bv  = out_tdata[2*VALUE_W-1:VALUE_W];
  assign occ = out_tdata[EMP_BIT-1:CNT_LSB];
  assign emp = out_tdata[EMP_BIT];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (emp == (occ == '0)) && (occ <= CNT_W'(DEPTH)))
    else $error("empty flag or occupancy inconsistent");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && emp |-> (fv == '0) && (bv == '0))
    else $error("empty queue shows nonzero words");

  a_pop_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> emp)
    else $error("pop error on nonempty queue");

  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind double_ended_queue_top dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
